FILE: src/lss_pkg.sv
package lss_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int DATA_W      = 32;
	localparam int CMD_W       = 3;
	localparam int STATUS_W    = 3;
	localparam int POS_W       = 6;

	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LIST   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_MATCH    = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_LISTED   = 3'd5;
	localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_WALK
	} state_t;

endpackage

FILE: src/lss_ram.sv
module lss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/lifo_stack_with_search.sv
// LIFO stack of signed 32-bit words with a linear search from the top.
// Input channel s_*: one item per command (push, pop, search, list, clear).
// Output channel m_*: result items; m_tlast marks the final item of a command.
// Push, clear, and a pop, search or list on an empty stack give their result
// in the cycle after the item is accepted; reserved commands give none. Pop
// fetches the top word from the single-port-read stack RAM, so its result
// passes the RAM read register and then the output register. Search and list
// read the RAM one entry per cycle from the top while no stall holds the walk;
// a search ends with a closing item after its matches.
// A new item is accepted only while no command is in progress and the
// output register is free or being emptied in the same cycle.
// When the receiver stalls, the output register holds its item and the RAM walk
// pauses at the next list entry or search match, held at the RAM output.
// Reset empties the stack and the output register at once; the RAM contents
// are not cleared and are only read below the entry count.
module lifo_stack_with_search #(
	parameter int STACK_DEPTH = lss_pkg::STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: command[2:0], data_value[34:3], zero fill[39:35].
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: status[2:0], result_value[34:3], position[40:35],
	// match_count[46:41], zero fill[47].
	output logic [47:0] m_tdata,
	output logic        m_tlast
);

	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int DW    = lss_pkg::DATA_W;
	localparam int PW    = lss_pkg::POS_W;
	localparam int SW    = lss_pkg::STATUS_W;

	lss_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W:0]   next_pos_q, next_pos_d;
	logic [CNT_W-1:0] pos_s1, pos_d;
	logic             pend_s1, pend_d;
	logic [CNT_W-1:0] matches_q, matches_d;
	logic [DW-1:0]    key_q, key_d;
	logic             search_q, search_d;

	logic             out_valid_q;
	logic [SW-1:0]    out_status_q, ld_status;
	logic [DW-1:0]    out_value_q, ld_value;
	logic [PW-1:0]    out_pos_q, ld_pos;
	logic [PW-1:0]    out_mc_q, ld_mc;
	logic             out_last_q, ld_last;
	logic             load_out;

	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [DW-1:0]    ram_rdata;

	logic [lss_pkg::CMD_W-1:0] in_cmd;
	logic [DW-1:0]    in_word;
	logic             out_free, full, empty, consume, issue, walk_done;
	logic [CNT_W:0]   walk_addr;
	logic [CNT_W-1:0] top_addr;

	assign in_cmd    = s_tdata[2:0];
	assign in_word   = s_tdata[34:3];
	assign out_free  = !out_valid_q || m_tready;
	assign full      = count_q == CNT_W'(STACK_DEPTH);
	assign empty     = count_q == '0;
	assign top_addr  = count_q - 1'b1;
	assign walk_addr = {1'b0, count_q} - next_pos_q;
	assign walk_done = next_pos_q > {1'b0, count_q};

	lss_ram #(
		.WIDTH(DW),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(in_word),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		next_pos_d = next_pos_q;
		pos_d      = pos_s1;
		pend_d     = pend_s1;
		matches_d  = matches_q;
		key_d      = key_q;
		search_d   = search_q;
		s_tready   = 1'b0;
		load_out   = 1'b0;
		ld_status  = lss_pkg::STAT_OK;
		ld_value   = '0;
		ld_pos     = '0;
		ld_mc      = '0;
		ld_last    = 1'b1;
		ram_we     = 1'b0;
		ram_waddr  = count_q[AW-1:0];
		ram_re     = 1'b0;
		ram_raddr  = top_addr[AW-1:0];
		consume    = 1'b0;
		issue      = 1'b0;
		case (state_q)
			lss_pkg::ST_IDLE: begin
				s_tready = out_free;
				if (s_tvalid && out_free) begin
					case (in_cmd)
						lss_pkg::CMD_PUSH: begin
							load_out = 1'b1;
							if (full) begin
								ld_status = lss_pkg::STAT_OVERFLOW;
							end else begin
								ram_we   = 1'b1;
								count_d  = count_q + 1'b1;
								ld_value = in_word;
								ld_pos   = PW'(1);
							end
						end
						lss_pkg::CMD_POP: begin
							if (empty) begin
								load_out  = 1'b1;
								ld_status = lss_pkg::STAT_EMPTY;
							end else begin
								ram_re  = 1'b1;
								count_d = top_addr;
								state_d = lss_pkg::ST_POP;
							end
						end
						lss_pkg::CMD_SEARCH, lss_pkg::CMD_LIST: begin
							key_d     = in_word;
							search_d  = in_cmd == lss_pkg::CMD_SEARCH;
							matches_d = '0;
							if (empty) begin
								load_out = 1'b1;
								if (in_cmd == lss_pkg::CMD_SEARCH) begin
									ld_status = lss_pkg::STAT_NOTFOUND;
									ld_value  = in_word;
								end else begin
									ld_status = lss_pkg::STAT_EMPTY;
								end
							end else begin
								ram_re     = 1'b1;
								pend_d     = 1'b1;
								pos_d      = CNT_W'(1);
								next_pos_d = (CNT_W + 1)'(2);
								state_d    = lss_pkg::ST_WALK;
							end
						end
						lss_pkg::CMD_CLEAR: begin
							load_out = 1'b1;
							count_d  = '0;
						end
						default: begin
						end
					endcase
				end
			end
			lss_pkg::ST_POP: begin
				load_out = 1'b1;
				ld_value = ram_rdata;
				ld_pos   = PW'(1);
				state_d  = lss_pkg::ST_IDLE;
			end
			lss_pkg::ST_WALK: begin
				ld_value = ram_rdata;
				ld_pos   = PW'(pos_s1);
				ld_last  = 1'b0;
				if (pend_s1) begin
					if (search_q) begin
						if (ram_rdata != key_q) begin
							consume = 1'b1;
						end else if (out_free) begin
							consume   = 1'b1;
							load_out  = 1'b1;
							ld_status = lss_pkg::STAT_MATCH;
							matches_d = matches_q + 1'b1;
						end
					end else if (out_free) begin
						consume   = 1'b1;
						load_out  = 1'b1;
						ld_status = lss_pkg::STAT_LISTED;
						ld_last   = pos_s1 == count_q;
						if (pos_s1 == count_q) begin
							state_d = lss_pkg::ST_IDLE;
						end
					end
				end
				issue     = (!pend_s1 || consume) && !walk_done;
				ram_re    = issue;
				ram_raddr = walk_addr[AW-1:0];
				if (issue) begin
					pend_d     = 1'b1;
					pos_d      = next_pos_q[CNT_W-1:0];
					next_pos_d = next_pos_q + 1'b1;
				end else if (consume) begin
					pend_d = 1'b0;
				end
				if (!pend_s1 && walk_done) begin
					if (search_q) begin
						if (out_free) begin
							load_out  = 1'b1;
							ld_status = (matches_q != '0) ? lss_pkg::STAT_FOUND
							                              : lss_pkg::STAT_NOTFOUND;
							ld_value  = key_q;
							ld_pos    = '0;
							ld_mc     = PW'(matches_q);
							ld_last   = 1'b1;
							state_d   = lss_pkg::ST_IDLE;
						end
					end else begin
						state_d = lss_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = lss_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lss_pkg::ST_IDLE;
			count_q     <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_s1 <= pend_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		next_pos_q <= next_pos_d;
		pos_s1     <= pos_d;
		matches_q  <= matches_d;
		key_q      <= key_d;
		search_q   <= search_d;
		if (load_out) begin
			out_status_q <= ld_status;
			out_value_q  <= ld_value;
			out_pos_q    <= ld_pos;
			out_mc_q     <= ld_mc;
			out_last_q   <= ld_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_mc_q, out_pos_q, out_value_q, out_status_q};
	assign m_tlast  = out_last_q;

endmodule

FILE: tb/lifo_stack_with_search_tb.sv
module lifo_stack_with_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [lss_pkg::CMD_W-1:0] CMD_RSVD0 = 3'd5;
	localparam logic [lss_pkg::CMD_W-1:0] CMD_RSVD1 = 3'd6;
	localparam logic [lss_pkg::CMD_W-1:0] CMD_RSVD2 = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 60;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [lss_pkg::STATUS_W-1:0] status;
		logic [lss_pkg::DATA_W-1:0]   value;
		logic [lss_pkg::POS_W-1:0]    position;
		logic [lss_pkg::POS_W-1:0]    match_cnt;
		logic                         last;
	} stack_reply_t;

	class stack_tracker;
		logic [lss_pkg::DATA_W-1:0] words [lss_pkg::STACK_DEPTH];
		int unsigned fill;
		stack_reply_t replies [$];
		int unsigned faults;
		int unsigned commands;
		int unsigned checked;
		int unsigned overflows;
		int unsigned empties;
		int unsigned hits;

		function void add_reply(logic [lss_pkg::STATUS_W-1:0] status,
				logic [lss_pkg::DATA_W-1:0] value, logic [lss_pkg::POS_W-1:0] position,
				logic [lss_pkg::POS_W-1:0] match_cnt, logic last);
			stack_reply_t r;
			r.status = status;
			r.value = value;
			r.position = position;
			r.match_cnt = match_cnt;
			r.last = last;
			replies.push_back(r);
		endfunction

		function void apply_command(logic [lss_pkg::CMD_W-1:0] cmd,
				logic [lss_pkg::DATA_W-1:0] word);
			int unsigned found;
			found = 0;
			commands++;
			case (cmd)
			lss_pkg::CMD_PUSH: begin
				if (fill >= lss_pkg::STACK_DEPTH) begin
					overflows++;
					add_reply(lss_pkg::STAT_OVERFLOW, '0, '0, '0, 1'b1);
				end else begin
					words[fill] = word;
					fill++;
					add_reply(lss_pkg::STAT_OK, word, 6'd1, '0, 1'b1);
				end
			end
			lss_pkg::CMD_POP: begin
				if (fill == 0) begin
					empties++;
					add_reply(lss_pkg::STAT_EMPTY, '0, '0, '0, 1'b1);
				end else begin
					fill--;
					add_reply(lss_pkg::STAT_OK, words[fill], 6'd1, '0, 1'b1);
				end
			end
			lss_pkg::CMD_SEARCH: begin
				for (int i = 0; i < fill; i++) begin
					if (words[fill - 1 - i] === word) begin
						add_reply(lss_pkg::STAT_MATCH, word, lss_pkg::POS_W'(i + 1), '0,
							1'b0);
						found++;
					end
				end
				hits += found;
				add_reply(found != 0 ? lss_pkg::STAT_FOUND : lss_pkg::STAT_NOTFOUND, word,
					'0, lss_pkg::POS_W'(found), 1'b1);
			end
			lss_pkg::CMD_LIST: begin
				if (fill == 0) begin
					empties++;
					add_reply(lss_pkg::STAT_EMPTY, '0, '0, '0, 1'b1);
				end else begin
					for (int i = 0; i < fill; i++)
						add_reply(lss_pkg::STAT_LISTED, words[fill - 1 - i],
							lss_pkg::POS_W'(i + 1), '0, i + 1 == fill);
				end
			end
			lss_pkg::CMD_CLEAR: begin
				fill = 0;
				add_reply(lss_pkg::STAT_OK, '0, '0, '0, 1'b1);
			end
			default: begin
			end
			endcase
		endfunction

		function void flag_field(string name, logic [lss_pkg::DATA_W-1:0] want,
				logic [lss_pkg::DATA_W-1:0] got);
			if (want !== got) begin
				faults++;
				$display("%0t: %s differs, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void compare_reply(logic [47:0] data, logic tlast);
			stack_reply_t want;
			checked++;
			if (replies.size() == 0) begin
				faults++;
				$display("%0t: item with nothing pending, expected none, actual %h last %b",
					$time, data, tlast);
				return;
			end
			want = replies.pop_front();
			flag_field("status", want.status, data[2:0]);
			flag_field("result_value", want.value, data[34:3]);
			flag_field("position", want.position, data[40:35]);
			flag_field("match_count", want.match_cnt, data[46:41]);
			flag_field("last", want.last, tlast);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tlast;

	stack_tracker tracker;
	logic [lss_pkg::DATA_W-1:0] pool [4];
	bit tx_gaps;
	bit rx_gaps;
	bit hold_request;
	int cycle_count;

	lifo_stack_with_search DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("lifo_stack_with_search: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.compare_reply(m_tdata, m_tlast);
	end

	// The long hold-off is counted here so the sender keeps offering items meanwhile.
	initial begin
		int off_cnt;
		off_cnt = 0;
		forever begin
			@(posedge clk);
			if (off_cnt == 0) begin
				if (hold_request) begin
					off_cnt = LONG_HOLD;
					hold_request = 1'b0;
				end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
					off_cnt = $urandom_range(1, 3);
				end
			end
			if (off_cnt > 0) begin
				m_tready <= 1'b0;
				off_cnt--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_command(input logic [lss_pkg::CMD_W-1:0] cmd,
			input logic [lss_pkg::DATA_W-1:0] word);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, word, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.apply_command(cmd, word);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [lss_pkg::DATA_W-1:0] pick_word();
		case ($urandom_range(0, 3))
		0, 1: return pool[$urandom_range(0, 3)];
		2: return $urandom;
		default: return lss_pkg::DATA_W'($signed($urandom_range(0, 6)) - 3);
		endcase
	endfunction

	function automatic logic [lss_pkg::CMD_W-1:0] pick_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 38)
			return lss_pkg::CMD_PUSH;
		if (r < 58)
			return lss_pkg::CMD_POP;
		if (r < 76)
			return lss_pkg::CMD_SEARCH;
		if (r < 86)
			return lss_pkg::CMD_LIST;
		if (r < 89)
			return lss_pkg::CMD_CLEAR;
		case ($urandom_range(0, 2))
		0: return CMD_RSVD0;
		1: return CMD_RSVD1;
		default: return CMD_RSVD2;
		endcase
	endfunction

	task automatic run_random(input int count);
		int done;
		logic [lss_pkg::CMD_W-1:0] cmd;
		done = 0;
		while (done < count) begin
			cmd = pick_command();
			send_command(cmd, pick_word());
			if (cmd <= lss_pkg::CMD_CLEAR)
				done++;
		end
	endtask

	initial begin
		tracker = new();
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		hold_request = 1'b0;
		cycle_count = 0;
		foreach (pool[i])
			pool[i] = $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(lss_pkg::CMD_POP, '0);
		send_command(lss_pkg::CMD_LIST, '0);
		send_command(lss_pkg::CMD_SEARCH, '0);
		send_command(lss_pkg::CMD_PUSH, 32'h7FFF_FFFF);
		send_command(lss_pkg::CMD_PUSH, 32'h8000_0000);
		send_command(lss_pkg::CMD_PUSH, 32'h0000_0000);
		send_command(lss_pkg::CMD_PUSH, 32'hFFFF_FFFF);
		send_command(lss_pkg::CMD_PUSH, 32'h8000_0000);
		send_command(lss_pkg::CMD_SEARCH, 32'h8000_0000);
		send_command(lss_pkg::CMD_SEARCH, 32'h0000_0005);
		send_command(lss_pkg::CMD_LIST, '0);
		send_command(CMD_RSVD0, 32'hFFFF_FFFF);
		send_command(CMD_RSVD1, 32'h8000_0000);
		send_command(CMD_RSVD2, 32'h7FFF_FFFF);
		send_command(lss_pkg::CMD_POP, '0);
		send_command(lss_pkg::CMD_POP, '0);
		send_command(lss_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
		send_command(lss_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
		send_command(lss_pkg::CMD_POP, '0);
		send_command(lss_pkg::CMD_LIST, '0);
		send_command(lss_pkg::CMD_CLEAR, '0);
		send_command(lss_pkg::CMD_PUSH, 32'h5555_5555);
		send_command(lss_pkg::CMD_PUSH, 32'hAAAA_AAAA);
		send_command(lss_pkg::CMD_LIST, '0);

		while (tracker.fill < lss_pkg::STACK_DEPTH)
			send_command(lss_pkg::CMD_PUSH, pick_word());
		send_command(lss_pkg::CMD_PUSH, pick_word());
		send_command(lss_pkg::CMD_PUSH, pick_word());
		send_command(lss_pkg::CMD_SEARCH, pool[0]);
		hold_request = 1'b1;
		send_command(lss_pkg::CMD_LIST, '0);
		send_command(lss_pkg::CMD_SEARCH, pool[1]);
		send_command(lss_pkg::CMD_POP, '0);
		send_command(lss_pkg::CMD_SEARCH, pick_word());

		for (int phase = 0; phase < 4; phase++) begin
			tx_gaps = $urandom_range(0, 2) != 0;
			rx_gaps = $urandom_range(0, 2) != 0;
			run_random(15);
		end

		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		run_random(15);
		s_tvalid <= 1'b0;

		while (tracker.replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d commands through the stack and checked %0d result items.",
			tracker.commands, tracker.checked);
		$display("Saw %0d overflows, %0d empty reports and %0d search matches.",
			tracker.overflows, tracker.empties, tracker.hits);
		if (tracker.faults == 0)
			$display("lifo_stack_with_search: match");
		else
			$display("lifo_stack_with_search: mismatch");
		$finish;
	end

endmodule
